// ===== rtl/core/itf_pkg.sv =====
// shared constants, types and the digit character table of the integer formatter
package itf_pkg;

  localparam int MAX_WIDTH  = 63;
  localparam int NUM_DIGITS = 20;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int VAL_W      = 64;
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int PAD_W      = 6;
  localparam int BITCNT_W   = $clog2(VAL_W + 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;

  // one conversion as handed to the character emitter
  typedef struct packed {
    logic [DIG_W-1:0]  digits;    // most significant digit in the top nibble
    logic [NDIG_W-1:0] ndig;
    logic              has_sign;
    logic [7:0]        sign_char;
    logic [PAD_W-1:0]  pad;
    logic              left;
  } itf_desc_t;

  // "0123456789abcdef"
  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_LOW_A + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/integer_to_text_formatter.sv =====
// top level of the integer to text formatter: input capture, digit search, sequencing
//
// usage:
//   in_*  : one word per conversion, a signed 64-bit value with its format
//           (base, field width, alignment, sign flags); taken while in_tready
//   out_* : one ASCII character per word, tlast on the final character
// sequence per conversion:
//   capture, then 64 shift-and-add-3 steps in the decimal unit and the hand-over
//   (hex skips the steps), then skipping leading zero digits and starting the
//   emitter, then one character a cycle while the sink takes them, then the
//   return to idle
// reset: synchronous active-low rst_n drops out_tvalid and returns to idle
// stall: a stalled sink holds the output word and freezes the character
//   sequencer; the next input word is taken once the last character is queued
module integer_to_text_formatter
  import itf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [63:0] value, [64] base_is_hex, [70:65] pad_width, [71] left_align,
  // [72] force_plus, [73] space_sign, [79:74] zero
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_char
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_NORM = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [PAD_W-1:0]  width_r, width_nxt;
  logic              left_r, left_nxt;
  logic              has_sign_r, has_sign_nxt;
  logic [7:0]        sign_r, sign_nxt;
  logic [DIG_W-1:0]  digit_r, digit_nxt;
  logic [NDIG_W-1:0] ndig_r, ndig_nxt;

  // input word fields
  logic [VAL_W-1:0] in_value;
  logic             in_hex;
  logic [PAD_W-1:0] in_width;
  logic             in_left, in_plus, in_space;
  logic             in_neg;
  logic [VAL_W-1:0] in_mag;
  logic             accept;

  logic             bcd_done;
  logic [DIG_W-1:0] bcd_digits;
  logic             emit_start;
  logic             emit_busy;
  itf_desc_t        desc;

  // field length and padding
  logic [PAD_W-1:0] width_sat;
  logic [PAD_W-1:0] field_len;
  logic [PAD_W-1:0] pad;

  assign in_value = in_tdata[63:0];
  assign in_hex   = in_tdata[64];
  assign in_width = in_tdata[70:65];
  assign in_left  = in_tdata[71];
  assign in_plus  = in_tdata[72];
  assign in_space = in_tdata[73];
  assign in_neg   = in_value[VAL_W-1];
  // most negative value negates onto itself, which is its true magnitude
  assign in_mag   = in_neg ? (VAL_W'(0) - in_value) : in_value;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  itf_bcd_unit u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .hex    (in_hex),
    .mag    (in_mag),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  // saturate the width, count the sign into the field
  assign width_sat = (int'(width_r) > MAX_WIDTH) ? PAD_W'(MAX_WIDTH) : width_r;
  assign field_len = PAD_W'(ndig_r) + {{(PAD_W-1){1'b0}}, has_sign_r};
  assign pad       = (width_sat > field_len) ? (width_sat - field_len) : '0;

  // normalizing ends once the top digit is nonzero or only one digit is left
  logic norm_done;
  assign norm_done = (digit_r[DIG_W-1 -: 4] != 4'd0) || (ndig_r == NDIG_W'(1));

  assign emit_start = (state_r == S_NORM) && norm_done;

  always_comb begin
    desc.digits    = digit_r;
    desc.ndig      = ndig_r;
    desc.has_sign  = has_sign_r;
    desc.sign_char = sign_r;
    desc.pad       = pad;
    desc.left      = left_r;
  end

  always_comb begin
    state_nxt    = state_r;
    width_nxt    = width_r;
    left_nxt     = left_r;
    has_sign_nxt = has_sign_r;
    sign_nxt     = sign_r;
    digit_nxt    = digit_r;
    ndig_nxt     = ndig_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          width_nxt    = in_width;
          left_nxt     = in_left;
          has_sign_nxt = in_neg || in_plus || in_space;
          if (in_neg) begin
            sign_nxt = CHAR_MINUS;
          end else if (in_plus) begin
            sign_nxt = CHAR_PLUS;
          end else begin
            sign_nxt = CHAR_SPACE;
          end
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          digit_nxt = bcd_digits;
          ndig_nxt  = NDIG_W'(NUM_DIGITS);
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (norm_done) begin
          state_nxt = S_EMIT;
        end else begin
          // drop one leading zero digit
          digit_nxt = {digit_r[DIG_W-5:0], 4'd0};
          ndig_nxt  = ndig_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (!emit_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    width_r    <= width_nxt;
    left_r     <= left_nxt;
    has_sign_r <= has_sign_nxt;
    sign_r     <= sign_nxt;
    digit_r    <= digit_nxt;
    ndig_r     <= ndig_nxt;
  end

  itf_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .desc       (desc),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // the emitter only runs while the sequencer waits on it
  a_busy_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_busy |-> (state_r == S_EMIT))
    else $error("emitter busy outside the emit state");

  // the emitter starts only after the leading zero search
  a_start_after_norm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(emit_busy) |-> $past(state_r == S_NORM))
    else $error("emitter started without a normalized digit string");

  // at least one digit is always kept
  a_ndig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM) |-> (ndig_r != '0))
    else $error("digit count reached zero");

  // the decimal unit is done before the digits are taken over
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) && (state_nxt == S_NORM) |-> bcd_done)
    else $error("digits taken before conversion finished");

endmodule

// ===== rtl/core/itf_bcd_unit.sv =====
// shift-and-add-3 binary to decimal digits, one bit per cycle; hex loads nibbles directly
module itf_bcd_unit
  import itf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             hex,
  input  logic [VAL_W-1:0] mag,
  output logic             done,
  output logic [DIG_W-1:0] digits
);

  logic [VAL_W-1:0]    mag_r, mag_nxt;
  logic [DIG_W-1:0]    bcd_r, bcd_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIG_W-1:0]    adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (start) begin
      if (hex) begin
        // hex digits are the nibbles themselves
        bcd_nxt = {{(DIG_W-VAL_W){1'b0}}, mag};
        cnt_nxt = '0;
      end else begin
        mag_nxt = mag;
        bcd_nxt = '0;
        cnt_nxt = BITCNT_W'(VAL_W);
      end
    end else if (cnt_r != '0) begin
      bcd_nxt = {adj[DIG_W-2:0], mag_r[VAL_W-1]};
      mag_nxt = {mag_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done   = (cnt_r == '0);
  assign digits = bcd_r;

endmodule

// ===== rtl/core/itf_emitter.sv =====
// character sequencer: left pad, sign, digits, right pad into a registered output word
module itf_emitter
  import itf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  itf_desc_t desc,
  output logic      busy,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata,
  output logic      out_tlast
);

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_SGN  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;
  localparam logic [1:0] PH_POST = 2'd3;

  logic              busy_r, busy_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [PAD_W-1:0]  pad_cnt_r, pad_cnt_nxt;
  logic [NDIG_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic [DIG_W-1:0]  digit_r, digit_nxt;
  logic              has_sign_r, has_sign_nxt;
  logic [7:0]        sign_r, sign_nxt;
  logic              left_r, left_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              advance;

  assign advance = busy_r && (!valid_r || out_tready);

  always_comb begin
    busy_nxt     = busy_r;
    phase_nxt    = phase_r;
    pad_cnt_nxt  = pad_cnt_r;
    dig_cnt_nxt  = dig_cnt_r;
    digit_nxt    = digit_r;
    has_sign_nxt = has_sign_r;
    sign_nxt     = sign_r;
    left_nxt     = left_r;
    valid_nxt    = valid_r && !out_tready;
    char_nxt     = char_r;
    last_nxt     = last_r;

    if (start) begin
      busy_nxt     = 1'b1;
      pad_cnt_nxt  = desc.pad;
      dig_cnt_nxt  = desc.ndig;
      digit_nxt    = desc.digits;
      has_sign_nxt = desc.has_sign;
      sign_nxt     = desc.sign_char;
      left_nxt     = desc.left;
      if (!desc.left && desc.pad != '0) begin
        phase_nxt = PH_PRE;
      end else if (desc.has_sign) begin
        phase_nxt = PH_SGN;
      end else begin
        phase_nxt = PH_DIG;
      end
    end else if (advance) begin
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
      unique case (phase_r)
        PH_PRE: begin
          char_nxt    = CHAR_SPACE;
          pad_cnt_nxt = pad_cnt_r - 1'b1;
          if (pad_cnt_r == PAD_W'(1)) begin
            phase_nxt = has_sign_r ? PH_SGN : PH_DIG;
          end
        end
        PH_SGN: begin
          char_nxt  = sign_r;
          phase_nxt = PH_DIG;
        end
        PH_DIG: begin
          char_nxt    = digit_char(digit_r[DIG_W-1 -: 4]);
          digit_nxt   = {digit_r[DIG_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
          if (dig_cnt_r == NDIG_W'(1)) begin
            if (left_r && pad_cnt_r != '0) begin
              phase_nxt = PH_POST;
            end else begin
              last_nxt = 1'b1;
              busy_nxt = 1'b0;
            end
          end
        end
        PH_POST: begin
          char_nxt    = CHAR_SPACE;
          pad_cnt_nxt = pad_cnt_r - 1'b1;
          if (pad_cnt_r == PAD_W'(1)) begin
            last_nxt = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
    phase_r    <= phase_nxt;
    pad_cnt_r  <= pad_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    digit_r    <= digit_nxt;
    has_sign_r <= has_sign_nxt;
    sign_r     <= sign_nxt;
    left_r     <= left_nxt;
    char_r     <= char_nxt;
    last_r     <= last_nxt;
  end

  assign busy       = busy_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

endmodule
